// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, character codes, result kinds and the job record that the
// front part hands to the back part.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int SAVE_DEPTH = 16;
  localparam int QDEPTH     = 4;

  localparam int LIN_W      = 11;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int SAVE_IDX_W = $clog2(SAVE_DEPTH);
  localparam int SAVE_CNT_W = $clog2(SAVE_DEPTH + 1);
  localparam int Q_IDX_W    = $clog2(QDEPTH);
  localparam int Q_CNT_W    = $clog2(QDEPTH + 1);

  localparam logic [COL_W-1:0] COL_LAST     = COL_W'(COLUMNS - 1);
  localparam logic [COL_W:0]   COLUMNS_X    = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W-1:0] ROW_LIMIT    = ROW_W'(ROWS);
  localparam logic [LIN_W-1:0] SCROLL_INDEX = LIN_W'((ROWS - 1) * COLUMNS);

  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_M      = 8'h6D;

  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    KIND_CURSOR = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_SCROLL = 2'd2,
    KIND_FILL   = 2'd3
  } kind_t;

  typedef struct packed {
    logic             has_pri;
    kind_t            pri_kind;
    logic [LIN_W-1:0] pri_index;
    logic [7:0]       pri_char;
    logic [7:0]       attr;
    logic             scroll;
    logic [LIN_W-1:0] cursor;
  } job_t;

endpackage

// ===== design/tcw_if.sv =====
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready channels for console bytes, frame-store commands and the
// configuration register.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] ch;

  modport source (output valid, operation, ch, input ready);
  modport sink (input valid, operation, ch, output ready);
endinterface

interface tcw_out_if;
  logic                      valid;
  logic                      ready;
  tcw_pkg::kind_t            kind;
  logic [tcw_pkg::LIN_W-1:0] cell_index;
  logic [15:0]               cell_word;
  logic [tcw_pkg::LIN_W-1:0] cursor;
  logic                      last;

  modport source (output valid, kind, cell_index, cell_word, cursor, last, input ready);
  modport sink (input valid, kind, cell_index, cell_word, cursor, last, output ready);
endinterface

interface tcw_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/tcw_front.sv =====
// ----------------------------------------------------------------------------
// Text console writer front end
// Accepts console beats, runs the escape parser and cursor arithmetic, and
// queues one job per beat that produces frame-store commands.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic          clk,
  input  logic          rst_n,
  tcw_in_if.sink        in_chan,
  tcw_cfg_if.sink       cfg_chan,
  input  logic          q_full,
  output logic          q_push,
  output tcw_pkg::job_t q_job
);
  import tcw_pkg::*;

  logic                  en_r, en_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [LIN_W-1:0]      lin_r, lin_nxt;
  logic                  esc_r, esc_nxt;
  logic                  br_r, br_nxt;
  logic [7:0]            attr_r, attr_nxt;
  logic [15:0]           dig_r, dig_nxt;
  logic [15:0]           back_r, back_nxt;
  logic [SAVE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]            save_r [SAVE_DEPTH];

  logic                  sv_we;
  logic [SAVE_IDX_W-1:0] sv_widx;
  logic [SAVE_IDX_W-1:0] sv_ridx;

  logic                  accept;
  logic [7:0]            ch;
  logic                  is_digit;
  logic [15:0]           dig_add;
  logic [2:0]            tab_step;
  logic [COL_W:0]        tab_sum;
  logic [COL_W:0]        tab_wrap;

  logic [ROW_W-1:0]      mv_row;
  logic [COL_W-1:0]      mv_col;
  logic                  mv_wr;
  logic [LIN_W-1:0]      mv_idx;
  logic [7:0]            mv_chr;
  logic                  mv_scroll;

  assign ch             = in_chan.ch;
  assign in_chan.ready  = !q_full;
  assign cfg_chan.ready = 1'b1;
  assign accept         = in_chan.valid && in_chan.ready;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dig_add  = {dig_r[12:0], 3'b000} + {12'd0, 4'(ch - CH_ZERO)};
  assign tab_step = 3'd4 - {1'b0, lin_r[1:0]};
  assign tab_sum  = {1'b0, col_r} + {{(COL_W - 2){1'b0}}, tab_step};
  assign tab_wrap = tab_sum - COLUMNS_X;

  // Cursor movement and cell write for a printable or control byte.
  always_comb begin
    mv_row    = row_r;
    mv_col    = col_r;
    mv_wr     = 1'b0;
    mv_idx    = lin_r;
    mv_chr    = ch;
    mv_scroll = 1'b0;
    if (ch >= CH_SPACE) begin
      mv_wr = 1'b1;
      if (col_r == COL_LAST) begin
        mv_col = '0;
        mv_row = row_r + 1'b1;
      end else begin
        mv_col = col_r + 1'b1;
      end
    end else begin
      case (ch)
        CH_LF: begin
          mv_col = '0;
          mv_row = row_r + 1'b1;
        end
        CH_BS: begin
          if (lin_r != '0) begin
            mv_wr  = 1'b1;
            mv_idx = lin_r - 1'b1;
            mv_chr = CH_SPACE;
            if (col_r != '0) begin
              mv_col = col_r - 1'b1;
            end else begin
              mv_col = COL_LAST;
              mv_row = row_r - 1'b1;
            end
          end
        end
        CH_TAB: begin
          if (tab_sum >= COLUMNS_X) begin
            mv_col = tab_wrap[COL_W-1:0];
            mv_row = row_r + 1'b1;
          end else begin
            mv_col = tab_sum[COL_W-1:0];
          end
        end
        CH_CR: begin
          mv_col = '0;
        end
        default: begin
        end
      endcase
    end
    if (mv_row == ROW_LIMIT) begin
      mv_scroll = 1'b1;
      mv_row    = mv_row - 1'b1;
    end
  end

  always_comb begin
    en_nxt   = en_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    esc_nxt  = esc_r;
    br_nxt   = br_r;
    attr_nxt = attr_r;
    dig_nxt  = dig_r;
    back_nxt = back_r;
    cnt_nxt  = cnt_r;
    sv_we    = 1'b0;
    sv_widx  = cnt_r[SAVE_IDX_W-1:0];
    sv_ridx  = (cnt_r >= SAVE_CNT_W'(2)) ? SAVE_IDX_W'(cnt_r - SAVE_CNT_W'(2)) : '0;
    q_push   = 1'b0;

    q_job.has_pri   = mv_wr;
    q_job.pri_kind  = KIND_WRITE;
    q_job.pri_index = mv_idx;
    q_job.pri_char  = mv_chr;
    q_job.attr      = attr_r;
    q_job.scroll    = mv_scroll;

    if (cfg_chan.valid) begin
      en_nxt = cfg_chan.data;
    end

    if (accept) begin
      if (in_chan.operation == OP_CLEAR) begin
        row_nxt         = '0;
        col_nxt         = '0;
        q_push          = 1'b1;
        q_job.has_pri   = 1'b1;
        q_job.pri_kind  = KIND_FILL;
        q_job.pri_index = '0;
        q_job.pri_char  = '0;
        q_job.scroll    = 1'b0;
      end else if (ch == CH_ESC) begin
        esc_nxt = 1'b1;
      end else if (esc_r) begin
        if (en_r) begin
          if (ch == CH_LBRACK) begin
            br_nxt = 1'b1;
            if (cnt_r < SAVE_CNT_W'(SAVE_DEPTH)) begin
              sv_we   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end else if (br_r) begin
            if (ch == CH_SEMI) begin
              br_nxt   = 1'b0;
              back_nxt = back_r + dig_r;
              dig_nxt  = '0;
            end else if (ch == CH_M) begin
              br_nxt   = 1'b0;
              esc_nxt  = 1'b0;
              back_nxt = '0;
              if (cnt_r != '0) begin
                attr_nxt = save_r[sv_ridx];
                cnt_nxt  = (cnt_r >= SAVE_CNT_W'(2)) ? cnt_r - SAVE_CNT_W'(2) : '0;
              end
            end else if (is_digit) begin
              dig_nxt = dig_add;
            end
          end else if (ch == CH_M) begin
            attr_nxt = {back_r[3:0], 4'b0000} | dig_r[7:0];
            dig_nxt  = '0;
            back_nxt = '0;
            esc_nxt  = 1'b0;
          end else if (is_digit) begin
            dig_nxt = dig_add;
          end
        end else if (ch == CH_M) begin
          esc_nxt = 1'b0;
        end
      end else begin
        row_nxt = mv_row;
        col_nxt = mv_col;
        q_push  = 1'b1;
      end
    end

    lin_nxt      = LIN_W'(LIN_W'(row_nxt) * LIN_W'(COLUMNS)) + LIN_W'(col_nxt);
    q_job.cursor = lin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      row_r  <= '0;
      col_r  <= '0;
      lin_r  <= '0;
      esc_r  <= 1'b0;
      br_r   <= 1'b0;
      attr_r <= ATTR_RESET;
      dig_r  <= '0;
      back_r <= '0;
      cnt_r  <= '0;
    end else begin
      en_r   <= en_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      lin_r  <= lin_nxt;
      esc_r  <= esc_nxt;
      br_r   <= br_nxt;
      attr_r <= attr_nxt;
      dig_r  <= dig_nxt;
      back_r <= back_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_we) begin
      save_r[sv_widx] <= attr_r;
    end
  end

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < ROW_LIMIT) && (col_r <= COL_LAST))
    else $error("Cursor left the screen.");

  a_save_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SAVE_CNT_W'(SAVE_DEPTH))
    else $error("Attribute save stack overran.");

  a_escape_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && esc_r && (in_chan.operation == OP_PUT)) |-> !q_push)
    else $error("A byte inside an escape produced a job.");

endmodule

// ===== design/tcw_queue.sv =====
// ----------------------------------------------------------------------------
// Text console writer job queue
// Short first-in first-out store of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output tcw_pkg::job_t head_job
);
  import tcw_pkg::*;

  job_t               mem_r [QDEPTH];
  logic [Q_IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == Q_CNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("Job pushed into a full queue.");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("Job popped from an empty queue.");

endmodule

// ===== design/tcw_back.sv =====
// ----------------------------------------------------------------------------
// Text console writer back end
// Expands each queued job into its frame-store commands, one beat per cycle
// while the output channel is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  tcw_pkg::job_t head_job,
  output logic          pop,
  tcw_out_if.source     out_chan
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    PH_PRI    = 3'b001,
    PH_SCROLL = 3'b010,
    PH_CURSOR = 3'b100
  } phase_t;

  phase_t           ph_r, ph_nxt, eff;
  logic             out_valid_r, out_valid_nxt;
  kind_t            kind_r;
  logic [LIN_W-1:0] idx_r;
  logic [15:0]      word_r;
  logic [LIN_W-1:0] cur_r;
  logic             last_r;

  kind_t            res_kind;
  logic [LIN_W-1:0] res_idx;
  logic [15:0]      res_word;
  logic             res_last;
  logic             load;

  always_comb begin
    eff = ph_r;
    if ((eff == PH_PRI) && !head_job.has_pri) begin
      eff = PH_SCROLL;
    end
    if ((eff == PH_SCROLL) && !head_job.scroll) begin
      eff = PH_CURSOR;
    end
    case (eff)
      PH_PRI: begin
        res_kind = head_job.pri_kind;
        res_idx  = head_job.pri_index;
        res_word = {head_job.attr, head_job.pri_char};
      end
      PH_SCROLL: begin
        res_kind = KIND_SCROLL;
        res_idx  = SCROLL_INDEX;
        res_word = {head_job.attr, CH_SPACE};
      end
      default: begin
        res_kind = KIND_CURSOR;
        res_idx  = '0;
        res_word = '0;
      end
    endcase
    res_last = (eff == PH_CURSOR);
    load     = head_valid && (!out_valid_r || out_chan.ready);
    pop      = load && res_last;

    ph_nxt = ph_r;
    if (load) begin
      if (res_last) begin
        ph_nxt = PH_PRI;
      end else if (eff == PH_PRI) begin
        ph_nxt = PH_SCROLL;
      end else begin
        ph_nxt = PH_CURSOR;
      end
    end

    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_PRI;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= res_kind;
      idx_r  <= res_idx;
      word_r <= res_word;
      cur_r  <= head_job.cursor;
      last_r <= res_last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.kind       = kind_r;
  assign out_chan.cell_index = idx_r;
  assign out_chan.cell_word  = word_r;
  assign out_chan.cursor     = cur_r;
  assign out_chan.last       = last_r;

endmodule

// ===== design/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// Text console writer core
// Turns console bytes and clear requests into frame-store commands for an
// 80 by 25 text screen, with colour escape parsing.
//
//   Channel   Direction  Beat carries
//   in_chan   sink       operation, ch
//   out_chan  source     kind, cell_index, cell_word, cursor, last
//   cfg_chan  sink       data (escape colours enable)
//
// An accepted byte's job goes through the queue and the output register.
// Each byte outside an escape gives one to three commands, and the single
// output register sends one per cycle while out_chan is ready.
// A four-job queue lets input continue while the output is stalled.
// Synchronous reset; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module text_console_writer_core (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_chan,
  tcw_out_if.source out_chan,
  tcw_cfg_if.sink   cfg_chan
);
  import tcw_pkg::*;

  logic q_push;
  job_t q_push_job;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  job_t q_head_job;

  tcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  tcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule
